FILE: rtl/ccae_pkg.sv
// Shared types, constants and ANSI sequence tables for the color code expander.
`default_nettype none

package ccae_pkg;

	localparam logic [7:0] COLOR_ESC_CHAR = 8'h03;
	localparam logic [7:0] IAC_CHAR       = 8'hff;
	localparam logic [7:0] DIGIT_ONE      = 8'h31;
	localparam logic [7:0] DIGIT_NINE     = 8'h39;
	localparam logic [7:0] DIGIT_ZERO     = 8'h30;

	localparam int QUEUE_DEPTH = 4;

	localparam int NUM_SEQ = 10;
	localparam int SEQ_MAX = 11;
	localparam int SEL_W   = 4;
	localparam int IDX_W   = 4;

	// What the back end has to do for one queued entry
	typedef enum logic [1:0] {
		CMD_BYTE     = 2'd0,  // pass one byte
		CMD_IAC_BYTE = 2'd1,  // deferred 255, then the byte
		CMD_SEQ      = 2'd2,  // ANSI sequence, selector in data
		CMD_MARK     = 2'd3   // empty chunk end marker
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic       chunk_end;
	} cmd_t;

	// Row 0 is the reset sequence; rows 1..9 follow color digits '1'..'9'
	localparam logic [7:0] SEQ_BYTES [0:NUM_SEQ-1][0:SEQ_MAX-1] = '{
		'{8'h1b, 8'h5b, 8'h30, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h31, 8'h3b, 8'h33, 8'h36, 8'h6d, 8'h00, 8'h00},
		'{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h31, 8'h3b, 8'h33, 8'h33, 8'h6d, 8'h00, 8'h00},
		'{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h33, 8'h35, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h31, 8'h3b, 8'h34, 8'h34, 8'h6d, 8'h00, 8'h00},
		'{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h33, 8'h32, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h31, 8'h3b, 8'h35, 8'h3b, 8'h33, 8'h31, 8'h6d},
		'{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h31, 8'h3b, 8'h33, 8'h34, 8'h6d, 8'h00, 8'h00},
		'{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h33, 8'h34, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h1b, 8'h5b, 8'h30, 8'h3b, 8'h33, 8'h36, 8'h6d, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [IDX_W-1:0] SEQ_LEN [0:NUM_SEQ-1] = '{
		4'd4, 4'd9, 4'd9, 4'd7, 4'd9, 4'd7, 4'd11, 4'd9, 4'd7, 4'd7
	};

endpackage

`default_nettype wire

FILE: rtl/ccae_front.sv
// Front end: accepts input transactions, tracks pending escapes, queues commands.
`default_nettype none

module ccae_front import ccae_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       mode_color,
	input  wire logic       ansi_on,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       chunk_end,
	input  wire logic       queue_full,
	output logic            push,
	output cmd_t            push_cmd
);

	logic color_pend_q;
	logic iac_pend_q;
	logic accept;
	logic emits;
	logic is_digit;

	assign in_stall = queue_full;
	assign accept   = in_valid & ~queue_full;
	assign is_digit = (in_byte >= DIGIT_ONE) && (in_byte <= DIGIT_NINE);

	always_comb begin
		emits              = 1'b1;
		push_cmd.kind      = CMD_BYTE;
		push_cmd.data      = in_byte;
		push_cmd.chunk_end = chunk_end;
		if (mode_color) begin
			if (in_byte == COLOR_ESC_CHAR) begin
				emits = 1'b0;
			end else if (color_pend_q) begin
				if (ansi_on) begin
					push_cmd.kind = CMD_SEQ;
					push_cmd.data = is_digit ? (in_byte - DIGIT_ZERO) : 8'd0;
				end else begin
					emits = 1'b0;
				end
			end
		end else if (iac_pend_q) begin
			push_cmd.kind = CMD_IAC_BYTE;
		end
		// silent byte closing a chunk still leaves a marker
		if (!emits) begin
			push_cmd.kind = CMD_MARK;
			push_cmd.data = 8'd0;
		end
	end

	assign push = accept & (emits | chunk_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_pend_q <= 1'b0;
			iac_pend_q   <= 1'b0;
		end else if (accept) begin
			if (mode_color) begin
				if (in_byte == COLOR_ESC_CHAR) begin
					color_pend_q <= 1'b1;
				end else begin
					color_pend_q <= 1'b0;
				end
			end else begin
				iac_pend_q <= (in_byte == IAC_CHAR);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ccae_fifo.sv
// Command queue between the front and back ends.
`default_nettype none

module ccae_fifo import ccae_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	input  wire logic pop,
	output cmd_t      head_cmd,
	output logic      empty,
	output logic      full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign head_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/ccae_back.sv
// Back end: expands queued commands into output bytes through an output register.
`default_nettype none

module ccae_back import ccae_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cmd_t      head_cmd,
	input  wire logic empty,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_stall,
	output logic [7:0] out_byte,
	output logic      byte_valid,
	output logic      last_of_run,
	output logic      chunk_end_out
);

	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             bvalid_q;
	logic             last_q;
	logic             cend_q;

	logic [SEL_W-1:0] sel;
	logic [7:0]       nxt_byte;
	logic             nxt_bvalid;
	logic             nxt_last;
	logic             load;

	assign sel = (head_cmd.kind == CMD_SEQ) ? head_cmd.data[SEL_W-1:0] : '0;

	always_comb begin
		nxt_byte   = head_cmd.data;
		nxt_bvalid = 1'b1;
		nxt_last   = 1'b1;
		unique case (head_cmd.kind)
			CMD_BYTE: begin
			end
			CMD_IAC_BYTE: begin
				if (idx_q == '0) begin
					nxt_byte = IAC_CHAR;
					nxt_last = 1'b0;
				end
			end
			CMD_SEQ: begin
				nxt_byte = SEQ_BYTES[sel][idx_q];
				nxt_last = (idx_q == SEQ_LEN[sel] - 1'b1);
			end
			CMD_MARK: begin
				nxt_byte   = 8'd0;
				nxt_bvalid = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign load = ~empty & (~out_valid_q | ~out_stall);
	assign pop  = load & nxt_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= nxt_last ? '0 : idx_q + 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= nxt_byte;
			bvalid_q <= nxt_bvalid;
			last_q   <= nxt_last;
			cend_q   <= nxt_last & head_cmd.chunk_end;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = byte_q;
	assign byte_valid    = bvalid_q;
	assign last_of_run   = last_q;
	assign chunk_end_out = cend_q;

endmodule

`default_nettype wire

FILE: rtl/color_code_ansi_expander.sv
// Top level of the color code / telnet IAC byte stream expander.
`default_nettype none

// Byte stream escaper. In color mode (mode_select = 1) a byte 3 arms an
// escape; the next byte becomes an ANSI color sequence (digits '1'..'9',
// anything else gives ESC[0m) or is dropped when ansi_enable is 0. In telnet
// mode every 255 is doubled, the extra 255 going out just before the next
// byte. An input that produces no byte but ends a chunk yields one marker
// transaction with byte_valid low. Both channels are valid/stall; a
// transaction moves when valid is high and stall is low.
// Rate: while out_stall is low the back end emits one output transaction per
// cycle, so plain bytes flow at one input per cycle, passing through a queue
// entry and then the output register. An expansion of up to 11 bytes holds
// the back end until its last byte is loaded; the front end keeps taking
// input until the QUEUE_DEPTH entry command queue fills, then raises in_stall.
// Registers (APB, 32-bit data): 0x0 mode_select, 0x4 ansi_enable. Write only
// while the stream is idle.

module color_code_ansi_expander import ccae_pkg::*; #(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// input stream
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        chunk_end,
	// output stream
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             last_of_run,
	output logic             chunk_end_out
);

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_ANSI = 1'b1;

	logic mode_q;
	logic ansi_q;
	logic cfg_wr;

	logic push;
	logic pop;
	logic empty;
	logic full;
	cmd_t push_cmd;
	cmd_t head_cmd;

	// register file; address bit 2 picks the register
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			ansi_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MODE: mode_q <= pwdata[0];
				REG_ANSI: ansi_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE: prdata = {31'd0, mode_q};
			REG_ANSI: prdata = {31'd0, ansi_q};
			default:  prdata = 32'd0;
		endcase
	end

	// front: classify and hold the pending-escape state
	ccae_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_color (mode_q),
		.ansi_on    (ansi_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.chunk_end  (chunk_end),
		.queue_full (full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// decouples input acceptance from sequence draining
	ccae_fifo #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (empty),
		.full     (full)
	);

	// back: one output byte per cycle into the output register while out_stall is low
	ccae_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_cmd      (head_cmd),
		.empty         (empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.last_of_run   (last_of_run),
		.chunk_end_out (chunk_end_out)
	);

endmodule

`default_nettype wire
